// ===== design/hd_pkg.sv =====
// Shared constants, types and functions of the haversine distance pipeline.
package hd_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int FRAC_BITS    = 30;

   localparam int QW = FRAC_BITS + 1;
   localparam int CW = FRAC_BITS + 3;
   localparam int AW = FRAC_BITS + 2;
   localparam int SW = 2 * FRAC_BITS + 2;
   localparam int UW = 28;

   typedef logic signed [CW-1:0] cw_type;
   typedef logic [QW-1:0]        q_type;
   typedef logic [AW-1:0]        ang_type;
   typedef logic [UW-1:0]        udeg_type;

   typedef struct packed {
      q_type s_dlat;
      q_type s_dlon;
      q_type c_lat_a;
      q_type c_lat_b;
   } trig_type;

   localparam logic signed [27:0] LAT_LIM = 28'sd90000000;
   localparam logic signed [28:0] LON_LIM = 29'sd180000000;

   localparam longint PI_Q60       = 64'h3243F6A8885A308D;
   localparam longint RAD_Q62      = (PI_Q60 + 64'd22500000) / 64'd45000000;
   localparam longint INV_GAIN_Q62 = 64'd2800459870029452967;

   localparam int CLW = 20;
   localparam int CHW = 17;
   localparam logic [CLW-1:0] RAD_LO = RAD_Q62[CLW-1:0];
   localparam logic [CHW-1:0] RAD_HI = RAD_Q62[CLW+CHW-1:CLW];
   localparam int PW = UW + CHW + CLW + 1;

   localparam cw_type X0 =
      CW'((INV_GAIN_Q62 + (longint'(1) << (61 - FRAC_BITS))) >>> (62 - FRAC_BITS));
   localparam cw_type ONE_CW = CW'(longint'(1) << FRAC_BITS);
   localparam q_type  ONE_Q  = QW'(longint'(1) << FRAC_BITS);

   localparam logic [23:0] TWO_R_M  = 24'd12742000;
   localparam logic [24:0] DIST_MAX = 25'd20015087;

   // shift-subtract quotient of non-negative values below 2^62
   function automatic longint div_q(longint n, longint d);
      longint q;
      longint r;
      int     b;
      q = 0;
      r = 0;
      for (b = 62; b >= 0; b--) begin
         r = (r << 1) | ((n >>> b) & longint'(1));
         if (r >= d) begin
            r = r - d;
            q = q | (longint'(1) << b);
         end
      end
      return q;
   endfunction

   // atan(2^-i) by truncated series in Q62, rounded to the working format
   function automatic cw_type atan_q(int i);
      longint v;
      longint term;
      int     k;
      v = 0;
      if (i == 0) begin
         v = PI_Q60;
      end else begin
         for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = div_q(longint'(1) << (62 - i * (2 * k + 1)), longint'(2 * k + 1));
            v    = ((k & 1) != 0) ? v - term : v + term;
         end
      end
      return CW'((v + (longint'(1) << (61 - FRAC_BITS))) >>> (62 - FRAC_BITS));
   endfunction

   function automatic q_type clamp_q(cw_type v);
      q_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > ONE_CW) begin
         r = ONE_Q;
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

   function automatic q_type round_q(logic [2*QW-1:0] m);
      logic [2*QW-1:0] t;
      t = (m + ((2*QW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return t[QW-1:0];
   endfunction

endpackage

// ===== design/hd_prep.sv =====
// Input clamping, angle differences and conversion to fixed-point radians.
module hd_prep import hd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [27:0]  lat_a,
   input  logic signed [28:0]  lon_a,
   input  logic signed [27:0]  lat_b,
   input  logic signed [28:0]  lon_b,
   output logic                out_valid,
   output cw_type              z [4]
);

   logic signed [27:0] la_c, lb_c;
   logic signed [28:0] oa_c, ob_c;
   logic signed [28:0] dlat, dlat_abs;
   logic signed [29:0] dlon, dlon_abs, dlon_w;
   logic signed [27:0] la_abs, lb_abs;
   udeg_type           u_in [4];

   udeg_type                u_ff  [4];
   logic [UW+CHW-1:0]       hi_ff [4];
   logic [UW+CLW-1:0]       lo_ff [4];
   cw_type                  z_ff  [4];
   logic [2:0]              v_ff;

   always_comb begin
      la_c = (lat_a > LAT_LIM) ? LAT_LIM : ((lat_a < -LAT_LIM) ? -LAT_LIM : lat_a);
      lb_c = (lat_b > LAT_LIM) ? LAT_LIM : ((lat_b < -LAT_LIM) ? -LAT_LIM : lat_b);
      oa_c = (lon_a > LON_LIM) ? LON_LIM : ((lon_a < -LON_LIM) ? -LON_LIM : lon_a);
      ob_c = (lon_b > LON_LIM) ? LON_LIM : ((lon_b < -LON_LIM) ? -LON_LIM : lon_b);
      dlat     = 29'(lb_c) - 29'(la_c);
      dlat_abs = dlat[28] ? -dlat : dlat;
      dlon     = 30'(ob_c) - 30'(oa_c);
      dlon_abs = dlon[29] ? -dlon : dlon;
      dlon_w   = (dlon_abs > 30'sd180000000) ? 30'sd360000000 - dlon_abs : dlon_abs;
      la_abs   = la_c[27] ? -la_c : la_c;
      lb_abs   = lb_c[27] ? -lb_c : lb_c;
      u_in[0]  = dlat_abs[UW-1:0];
      u_in[1]  = dlon_w[UW-1:0];
      u_in[2]  = la_abs;
      u_in[3]  = lb_abs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      localparam int SH = (l < 2) ? 63 - FRAC_BITS : 62 - FRAC_BITS;
      logic [PW-1:0] p;
      logic [PW-1:0] pr;
      assign p  = (PW'(hi_ff[l]) << CLW) + PW'(lo_ff[l]);
      assign pr = (p + (PW'(1) << (SH - 1))) >> SH;
      always_ff @(posedge clock) begin
         if (en) begin
            u_ff[l]  <= u_in[l];
            hi_ff[l] <= u_ff[l] * RAD_HI;
            lo_ff[l] <= u_ff[l] * RAD_LO;
            z_ff[l]  <= pr[CW-1:0];
         end
      end
      assign z[l] = z_ff[l];
   end

   assign out_valid = v_ff[2];

endmodule

// ===== design/hd_cordic_rot.sv =====
// Four-lane pipelined rotation CORDIC giving the sines and cosines.
module hd_cordic_rot import hd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  cw_type   z [4],
   output logic     out_valid,
   output trig_type trig
);

   cw_type x_ff [4][CORDIC_STEPS];
   cw_type y_ff [4][CORDIC_STEPS];
   cw_type z_ff [4][CORDIC_STEPS];
   logic [CORDIC_STEPS-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[CORDIC_STEPS-2:0], in_valid};
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
         localparam cw_type AT = atan_q(i);
         cw_type xp, yp, zp;
         if (i == 0) begin : g_first
            assign xp = X0;
            assign yp = '0;
            assign zp = z[l];
         end else begin : g_next
            assign xp = x_ff[l][i-1];
            assign yp = y_ff[l][i-1];
            assign zp = z_ff[l][i-1];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               if (zp >= 0) begin
                  x_ff[l][i] <= xp - (yp >>> i);
                  y_ff[l][i] <= yp + (xp >>> i);
                  z_ff[l][i] <= zp - AT;
               end else begin
                  x_ff[l][i] <= xp + (yp >>> i);
                  y_ff[l][i] <= yp - (xp >>> i);
                  z_ff[l][i] <= zp + AT;
               end
            end
         end
      end
   end

   assign trig.s_dlat  = clamp_q(y_ff[0][CORDIC_STEPS-1]);
   assign trig.s_dlon  = clamp_q(y_ff[1][CORDIC_STEPS-1]);
   assign trig.c_lat_a = clamp_q(x_ff[2][CORDIC_STEPS-1]);
   assign trig.c_lat_b = clamp_q(x_ff[3][CORDIC_STEPS-1]);
   assign out_valid    = v_ff[CORDIC_STEPS-1];

endmodule

// ===== design/hd_sqrt.sv =====
// Two-lane pipelined floor square root, one result bit per stage.
module hd_sqrt import hd_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   input  logic  en,
   input  logic  in_valid,
   input  q_type v [2],
   output logic  out_valid,
   output q_type root [2]
);

   localparam int NS = FRAC_BITS + 1;

   logic [SW-1:0] op_ff  [2][NS];
   logic [SW-1:0] res_ff [2][NS];
   logic [NS-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-2:0], in_valid};
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      for (genvar j = 0; j < NS; j++) begin : g_bit
         localparam logic [SW-1:0] BIT = SW'(1) << (2 * (FRAC_BITS - j));
         logic [SW-1:0] opp, resp, sum;
         if (j == 0) begin : g_first
            assign opp  = SW'(v[l]) << FRAC_BITS;
            assign resp = '0;
         end else begin : g_next
            assign opp  = op_ff[l][j-1];
            assign resp = res_ff[l][j-1];
         end
         assign sum = resp + BIT;
         always_ff @(posedge clock) begin
            if (en) begin
               if (opp >= sum) begin
                  op_ff[l][j]  <= opp - sum;
                  res_ff[l][j] <= (resp >> 1) + BIT;
               end else begin
                  op_ff[l][j]  <= opp;
                  res_ff[l][j] <= resp >> 1;
               end
            end
         end
      end
      assign root[l] = res_ff[l][NS-1][QW-1:0];
   end

   assign out_valid = v_ff[NS-1];

endmodule

// ===== design/hd_cordic_vec.sv =====
// Pipelined vectoring CORDIC giving the central half angle.
module hd_cordic_vec import hd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  q_type   x,
   input  q_type   y,
   output logic    out_valid,
   output ang_type ang
);

   cw_type x_ff [CORDIC_STEPS];
   cw_type y_ff [CORDIC_STEPS];
   cw_type z_ff [CORDIC_STEPS];
   logic [CORDIC_STEPS-1:0] v_ff;
   cw_type zl;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[CORDIC_STEPS-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
      localparam cw_type AT = atan_q(i);
      cw_type xp, yp, zp;
      if (i == 0) begin : g_first
         assign xp = CW'(x);
         assign yp = CW'(y);
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (yp > 0) begin
               x_ff[i] <= xp + (yp >>> i);
               y_ff[i] <= yp - (xp >>> i);
               z_ff[i] <= zp + AT;
            end else begin
               x_ff[i] <= xp - (yp >>> i);
               y_ff[i] <= yp + (xp >>> i);
               z_ff[i] <= zp - AT;
            end
         end
      end
   end

   assign zl        = z_ff[CORDIC_STEPS-1];
   assign ang       = (zl < 0) ? '0 : zl[AW-1:0];
   assign out_valid = v_ff[CORDIC_STEPS-1];

endmodule

// ===== design/haversine_distance.sv =====
// Haversine great-circle distance: one position pair in, distance in meters out.
// Throughput: one word per cycle; the pipeline stalls as a whole only while a
// result waits at the output and rsp_ready is low.
// The depth comes from one CORDIC iteration per stage (rotation and vectoring) and
// one square-root bit per stage.
// Reset (synchronous) clears all stage valid bits; no other state.
module haversine_distance import hd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [24:0]        rsp_distance_m
);

   logic     en;
   logic     prep_v, rot_v, sq_v, vec_v;
   cw_type   z [4];
   trig_type trig;
   q_type    sq_in [2];
   q_type    sq_out [2];
   ang_type  ang;

   logic [2*QW-1:0] m_s1_ff, m_s2_ff, m_cc_ff, m_x_ff;
   q_type           r_s1_ff, a_ff, b_ff;
   logic [2:0]      pv_ff;
   logic [AW+23:0]  dm_ff;
   logic            dv_ff;
   logic            rsp_valid_ff;
   logic [24:0]     rsp_distance_m_ff;

   q_type           a_sum;
   logic [QW:0]     a_wide;
   logic [AW+23:0]  d_r;
   logic [24:0]     d_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   hd_prep u_prep (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .lat_a(req_lat_a), .lon_a(req_lon_a), .lat_b(req_lat_b), .lon_b(req_lon_b),
      .out_valid(prep_v), .z(z)
   );

   hd_cordic_rot u_rot (
      .clock(clock), .reset(reset), .en(en), .in_valid(prep_v), .z(z),
      .out_valid(rot_v), .trig(trig)
   );

   always_comb begin
      a_sum  = round_q(m_x_ff);
      a_wide = (QW+1)'(r_s1_ff) + (QW+1)'(a_sum);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_s1_ff <= (2*QW)'(trig.s_dlat) * (2*QW)'(trig.s_dlat);
         m_s2_ff <= (2*QW)'(trig.s_dlon) * (2*QW)'(trig.s_dlon);
         m_cc_ff <= (2*QW)'(trig.c_lat_a) * (2*QW)'(trig.c_lat_b);
         r_s1_ff <= round_q(m_s1_ff);
         m_x_ff  <= (2*QW)'(round_q(m_cc_ff)) * (2*QW)'(round_q(m_s2_ff));
         if (a_wide > (QW+1)'(ONE_Q)) begin
            a_ff <= ONE_Q;
            b_ff <= '0;
         end else begin
            a_ff <= a_wide[QW-1:0];
            b_ff <= ONE_Q - a_wide[QW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[1:0], rot_v};
      end
   end

   assign sq_in[0] = b_ff;
   assign sq_in[1] = a_ff;

   hd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(pv_ff[2]), .v(sq_in),
      .out_valid(sq_v), .root(sq_out)
   );

   hd_cordic_vec u_vec (
      .clock(clock), .reset(reset), .en(en), .in_valid(sq_v),
      .x(sq_out[0]), .y(sq_out[1]), .out_valid(vec_v), .ang(ang)
   );

   always_comb begin
      d_r  = (dm_ff + ((AW+24)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      d_in = (d_r > (AW+24)'(DIST_MAX)) ? DIST_MAX : d_r[24:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm_ff             <= (AW+24)'(ang) * (AW+24)'(TWO_R_M);
         rsp_distance_m_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         dv_ff        <= vec_v;
         rsp_valid_ff <= dv_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance_m = rsp_distance_m_ff;

endmodule

// ===== verif/haversine_distance_test.sv =====
// Haversine distance testbench: directed and random position pairs, scoreboard check.
`timescale 1ns / 100ps

module haversine_distance_test;
   import hd_pkg::*;

   localparam int  LATENCY      = 2 * CORDIC_STEPS + FRAC_BITS + 9;
   localparam int  RANDOM_WORDS = 400;
   localparam int  RAD_PREC     = 62;
   localparam longint DIST_CAP  = 20015087;
   localparam longint RADIUS_M  = 6371000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [27:0] req_lat_a = '0;
   logic signed [28:0] req_lon_a = '0;
   logic signed [27:0] req_lat_b = '0;
   logic signed [28:0] req_lon_b = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [24:0]        rsp_distance_m;

   bit failed = 1'b0;
   bit stim_done = 1'b0;

   always #1 clock = ~clock;

   haversine_distance dut (.*);

   // round_half_up(a * b / 2^sh), 128-bit product
   function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = 128'(a) * 128'(b) + (128'(1) << (sh - 1));
      return 64'(p >> sh);
   endfunction

   function automatic longint arctan_entry(int i);
      longint v;
      longint term;
      v = 0;
      if (i == 0) begin
         v = PI_Q60;
      end else begin
         for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = longint'((64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1));
            v = (k % 2 == 1) ? v - term : v + term;
         end
      end
      return longint'((64'(v) + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // rotation CORDIC; returns {sin, cos} clamped to [0,1]
   function automatic void sin_cos(longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      x = longint'((64'(INV_GAIN_Q62) + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
      y = 0;
      z = ang;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_entry(i);
         end else begin
            x += dx; y -= dy; z += arctan_entry(i);
         end
      end
      s = clip(y, 0, longint'(1) << FRAC_BITS);
      c = clip(x, 0, longint'(1) << FRAC_BITS);
   endfunction

   function automatic longint arctan2(longint x0, longint y0);
      longint x, y, z, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_entry(i);
         end else begin
            x -= dx; y += dy; z -= arctan_entry(i);
         end
      end
      return z < 0 ? 0 : z;
   endfunction

   function automatic longint root_q(longint v);
      logic [127:0] target;
      logic [63:0]  r, t;
      target = 128'(v) << FRAC_BITS;
      r = 0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (128'(t) * 128'(t) <= target) r = t;
      end
      return longint'(r);
   endfunction

   function automatic longint udeg_rad(longint u, int half);
      return longint'(mul_round(64'(u), 64'(RAD_Q62), RAD_PREC - FRAC_BITS + half));
   endfunction

   function automatic logic [24:0] great_circle_m(longint la, longint oa, longint lb,
                                                  longint ob);
      longint dlat, dlon, s1, s2, ca, cb, junk, one, a, ang, d;
      one = longint'(1) << FRAC_BITS;
      la = clip(la, -90000000, 90000000);
      lb = clip(lb, -90000000, 90000000);
      oa = clip(oa, -180000000, 180000000);
      ob = clip(ob, -180000000, 180000000);
      dlat = lb - la;
      dlon = ob - oa;
      if (dlat < 0) dlat = -dlat;
      if (dlon < 0) dlon = -dlon;
      if (dlon > 180000000) dlon = 360000000 - dlon;
      if (la < 0) la = -la;
      if (lb < 0) lb = -lb;
      sin_cos(udeg_rad(dlat, 1), s1, junk);
      sin_cos(udeg_rad(dlon, 1), s2, junk);
      sin_cos(udeg_rad(la, 0), junk, ca);
      sin_cos(udeg_rad(lb, 0), junk, cb);
      a = longint'(mul_round(64'(s1), 64'(s1), FRAC_BITS))
        + longint'(mul_round(mul_round(64'(ca), 64'(cb), FRAC_BITS),
                             mul_round(64'(s2), 64'(s2), FRAC_BITS), FRAC_BITS));
      if (a > one) a = one;
      ang = arctan2(root_q(one - a), root_q(a));
      d = longint'(mul_round(64'(2 * ang), 64'(RADIUS_M), FRAC_BITS));
      if (d > DIST_CAP) d = DIST_CAP;
      return 25'(d);
   endfunction

   class distance_board;
      logic [24:0] pending[$];

      function void note_pair(longint la, longint oa, longint lb, longint ob);
         pending = {pending, great_circle_m(la, oa, lb, ob)};
      endfunction

      function void check_distance(logic [24:0] got);
         logic [24:0] want;
         if (pending.size() == 0) begin
            $error("unexpected word: distance_m %0d", got);
            failed = 1'b1;
         end else begin
            want = pending.pop_front();
            if (got !== want) begin
               $error("distance_m mismatch: expected %0d, actual %0d", want, got);
               failed = 1'b1;
            end
         end
      endfunction
   endclass

   distance_board board = new();

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_pair(req_lat_a, req_lon_a, req_lat_b, req_lon_b);
      if (!reset && rsp_valid && rsp_ready)
         board.check_distance(rsp_distance_m);
   end

   // receiver stall pattern: phases of always-ready and random stalls
   initial begin
      int phase;
      phase = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         phase++;
         if ((phase / 300) % 3 == 0) rsp_ready <= 1'b1;
         else if ((phase / 300) % 3 == 1) rsp_ready <= ($urandom_range(3) != 0);
         else rsp_ready <= ($urandom_range(4) == 0);
      end
   end

   task automatic send_pair(longint la, longint oa, longint lb, longint ob);
      req_lat_a <= 28'(la);
      req_lon_a <= 29'(oa);
      req_lat_b <= 28'(lb);
      req_lon_b <= 29'(ob);
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic longint any_lat();
      case ($urandom_range(9))
         0: return longint'($signed(28'($urandom())));
         1: return $urandom_range(1) ? 90000000 : -90000000;
         default: return longint'($urandom_range(180000000)) - 90000000;
      endcase
   endfunction

   function automatic longint any_lon();
      case ($urandom_range(9))
         0: return longint'($signed(29'($urandom())));
         1: return $urandom_range(1) ? 180000000 : -180000000;
         default: return longint'($urandom_range(360000000)) - 180000000;
      endcase
   endfunction

   initial begin
      int burst;
      longint la, oa;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, antipodes, wrap, identical points, out of range
      send_pair(0, 0, 0, 0);
      send_pair(90000000, 0, -90000000, 0);
      send_pair(0, 0, 0, 180000000);
      send_pair(0, -180000000, 0, 180000000);
      send_pair(0, 179999999, 0, -179999999);
      send_pair(45000000, 10000000, 45000000, 10000000);
      send_pair(45000000, 10000000, 45000001, 10000000);
      send_pair(-90000000, -180000000, 90000000, 180000000);
      send_pair(-134217728, -268435456, 134217727, 268435455);
      send_pair(134217727, 268435455, -134217728, -268435456);
      send_pair(100000000, 0, 90000000, 0);
      send_pair(0, 200000000, 0, -200000000);
      send_pair(1, 0, -1, 0);
      send_pair(0, 90000000, 0, -90000000);
      send_pair(51500000, -120000, 40700000, -74000000);
      send_pair(-33900000, 151200000, 35700000, 139700000);
      send_pair(0, 0, 0, 179999999);
      for (int n = 0; n < RANDOM_WORDS;) begin
         burst = $urandom_range(40, 1);
         for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++) begin
            if ($urandom_range(4) == 0) begin
               la = any_lat();
               oa = any_lon();
               send_pair(la, oa, la + $urandom_range(2000) - 1000,
                         oa + $urandom_range(2000) - 1000);
            end else begin
               send_pair(any_lat(), any_lon(), any_lat(), any_lon());
            end
         end
         if ($urandom_range(2) != 0) idle_cycles($urandom_range(15, 1));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (!failed && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
